/* hw/rtl/utf8d_pkg.sv */
package utf8d_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_end;
    logic        stream_done;
  } out_word_t;

  typedef struct packed {
    logic        lead_repl;
    logic [15:0] code_unit;
    logic        replaced;
    logic        final_byte;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam int          QueueDepthDef = 4;
  localparam logic [15:0] ReplChar      = 16'h003F;

endpackage

/* hw/rtl/utf8d_front.sv */
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_word_t in_data,
  input  logic     accept,
  output logic     push,
  output q_entry_t entry
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhLead = 2'd1;
  localparam logic [1:0] PhCont = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic        has;
  logic [7:0]  b;
  logic        fin;
  logic        is_cont;
  logic        fr_has;
  logic [15:0] fr_unit;

  always_comb begin
    b        = in_data.data_byte;
    fin      = in_data.final_byte;
    is_cont  = (b[7:6] == 2'b10);
    fr_has   = !b[7] || fin;
    fr_unit  = b[7] ? ReplChar : {8'h00, b};
    phase_nxt = phase_r;
    lead_nxt  = lead_r;
    sec_nxt   = sec_r;
    has       = 1'b0;
    entry     = '{lead_repl: 1'b0, code_unit: ReplChar, replaced: 1'b1, final_byte: fin};
    case (phase_r)
      PhLead, PhCont: begin
        if (!is_cont) begin
          has       = 1'b1;
          phase_nxt = PhIdle;
          if (fr_has) begin
            entry.lead_repl = 1'b1;
            entry.code_unit = fr_unit;
            entry.replaced  = b[7];
          end else begin
            lead_nxt  = b;
            phase_nxt = PhLead;
          end
        end else if (phase_r == PhLead) begin
          if (lead_r[7:5] == 3'b110) begin
            has             = 1'b1;
            phase_nxt       = PhIdle;
            entry.code_unit = {5'd0, lead_r[4:0], b[5:0]};
            entry.replaced  = 1'b0;
          end else if (fin) begin
            has       = 1'b1;
            phase_nxt = PhIdle;
          end else begin
            sec_nxt   = b[5:0];
            phase_nxt = PhCont;
          end
        end else begin
          has             = 1'b1;
          phase_nxt       = PhIdle;
          entry.code_unit = {lead_r[3:0], sec_r, b[5:0]};
          entry.replaced  = 1'b0;
        end
      end
      default: begin
        phase_nxt = PhIdle;
        if (fr_has) begin
          has             = 1'b1;
          entry.code_unit = fr_unit;
          entry.replaced  = b[7];
        end else begin
          lead_nxt  = b;
          phase_nxt = PhLead;
        end
      end
    endcase
    if (fin) begin
      phase_nxt = PhIdle;
    end
    push = accept && has;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhIdle;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lead_r <= lead_nxt;
      sec_r  <= sec_nxt;
    end
  end

endmodule

/* hw/rtl/utf8d_fifo.sv */
module utf8d_fifo
  import utf8d_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  q_entry_t   wr_entry,
  input  logic       pop,
  output q_entry_t   head,
  output fifo_stat_t stat
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  q_entry_t        mem [Depth];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign stat.full  = (count_r == CW'(Depth));
  assign stat.empty = (count_r == '0);
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/utf8d_back.sv */
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  fifo_stat_t stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;
  logic      part_r, part_nxt;
  logic      load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;

  always_comb begin
    pop          = 1'b0;
    part_nxt     = part_r;
    out_data_nxt = out_data_r;
    if (load && !stat.empty) begin
      if (head.lead_repl && !part_r) begin
        out_data_nxt = '{code_unit: ReplChar, replaced: 1'b1, run_end: 1'b0,
                         stream_done: 1'b0};
        part_nxt     = 1'b1;
      end else begin
        out_data_nxt = '{code_unit: head.code_unit, replaced: head.replaced,
                         run_end: 1'b1, stream_done: head.final_byte};
        part_nxt     = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      part_r      <= 1'b0;
    end else begin
      part_r <= part_nxt;
      if (load) begin
        out_valid_r <= !stat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

/* hw/rtl/utf8_byte_stream_decoder_top.sv */
// channel  dir  handshake          payload
// in_      in   in_valid/in_stall   in_word_t  {data_byte, final_byte}
// out_     out  out_valid/out_stall out_word_t {code_unit, replaced, run_end, stream_done}
//
// One byte per cycle enters while in_stall is low; it reaches out_ through the queue and then the output register.
// A broken sequence gives two words, and the back end holds its queue entry until both are sent.
// The front end keeps taking bytes until the QueueDepth-entry queue is full.
// rst_n is synchronous, active low; it empties the queue and the output register.
module utf8_byte_stream_decoder_top
  import utf8d_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic       accept;
  logic       push;
  logic       pop;
  q_entry_t   entry;
  q_entry_t   head;
  fifo_stat_t stat;

  assign in_stall = stat.full;
  assign accept   = in_valid && !stat.full;

  utf8d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .accept  (accept),
    .push    (push),
    .entry   (entry)
  );

  utf8d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/utf8d_checker.sv */
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out word changed while stalled");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_done |-> out_data.run_end)
    else $error("stream_done without run_end");

  a_repl_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.replaced |-> out_data.code_unit == ReplChar)
    else $error("replacement word is not '?'");

  a_first_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |-> out_data.replaced && !out_data.stream_done)
    else $error("leading word of a pair is not a replacement");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_end |=> out_valid)
    else $error("second word of a pair did not follow");

endmodule

bind utf8_byte_stream_decoder_top utf8d_checker u_chk (.*);

/* bench/tb_utf8_byte_stream_decoder_top.sv */
module tb_utf8_byte_stream_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned DrainCycles = 16;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_CONT = 2'd2
  } dec_phase_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  out_word_t   expected_units[$];
  dec_phase_e  dec_phase = PH_IDLE;
  logic [7:0]  dec_lead  = '0;
  logic [5:0]  dec_cont  = '0;
  int unsigned step_units;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_mode     = 0;
  bit          gaps_on        = 1'b1;

  utf8_byte_stream_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= cycle_count[1];
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: code_unit=%h replaced=%b run_end=%b stream_done=%b",
                   out_data.code_unit, out_data.replaced, out_data.run_end,
                   out_data.stream_done);
      end else begin
        want = expected_units.pop_front();
        if (out_data.code_unit !== want.code_unit || out_data.replaced !== want.replaced ||
            out_data.run_end !== want.run_end || out_data.stream_done !== want.stream_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("word mismatch: expected %h/%b/%b/%b actual %h/%b/%b/%b",
                     want.code_unit, want.replaced, want.run_end, want.stream_done,
                     out_data.code_unit, out_data.replaced, out_data.run_end,
                     out_data.stream_done);
        end
      end
    end
  end

  task automatic push_unit(input logic [15:0] unit, input logic repl);
    out_word_t u;
    u.code_unit   = unit;
    u.replaced    = repl;
    u.run_end     = 1'b0;
    u.stream_done = 1'b0;
    expected_units.push_back(u);
    step_units++;
  endtask

  task automatic decode_fresh(input logic [7:0] b, input logic fin);
    if (!b[7]) begin
      push_unit({8'h00, b}, 1'b0);
    end else if (fin) begin
      push_unit(ReplChar, 1'b1);
    end else begin
      dec_lead  = b;
      dec_phase = PH_LEAD;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] c;
    out_word_t  last;
    c = b ^ 8'h80;
    step_units = 0;
    if (dec_phase == PH_LEAD || dec_phase == PH_CONT) begin
      if (c[7:6] != 2'b00) begin
        dec_phase = PH_IDLE;
        push_unit(ReplChar, 1'b1);
        decode_fresh(b, fin);
      end else if (dec_phase == PH_LEAD) begin
        if (dec_lead[7:5] == 3'b110) begin
          dec_phase = PH_IDLE;
          push_unit({5'd0, dec_lead[4:0], c[5:0]}, 1'b0);
        end else if (fin) begin
          dec_phase = PH_IDLE;
          push_unit(ReplChar, 1'b1);
        end else begin
          dec_cont  = c[5:0];
          dec_phase = PH_CONT;
        end
      end else begin
        dec_phase = PH_IDLE;
        push_unit({dec_lead[3:0], dec_cont, c[5:0]}, 1'b0);
      end
    end else begin
      dec_phase = PH_IDLE;
      decode_fresh(b, fin);
    end
    if (fin)
      dec_phase = PH_IDLE;
    if (step_units > 0) begin
      last             = expected_units.pop_back();
      last.run_end     = 1'b1;
      last.stream_done = fin;
      expected_units.push_back(last);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= {b, fin};
    do @(posedge clk); while (in_stall);
    decode_byte(b, fin);
  endtask

  function automatic logic pick_fin();
    return ($urandom_range(0, 11) == 0);
  endfunction

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h3F, 1'b1);
  endtask

  task automatic test_two_byte();
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_three_byte();
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_broken();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
  endtask

  task automatic test_truncated();
    send_byte(8'hC5, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_random();
    int unsigned n;
    int unsigned next_switch;
    int unsigned kind;
    logic [7:0]  r;
    logic [7:0]  lead;
    n = 0;
    next_switch = 0;
    while (n < RandomItems) begin
      if (n >= next_switch) begin
        gaps_on     = ($urandom_range(0, 3) != 0);
        next_switch = n + $urandom_range(60, 160);
      end
      kind = $urandom_range(0, 19);
      r = 8'($urandom);
      if (kind < 7) begin
        send_byte({1'b0, r[6:0]}, pick_fin());
        n += 1;
      end else if (kind < 12) begin
        send_byte({3'b110, r[4:0]}, pick_fin());
        r = 8'($urandom);
        send_byte({2'b10, r[5:0]}, pick_fin());
        n += 2;
      end else if (kind < 17) begin
        case ($urandom_range(0, 5))
          0: lead = {2'b10, r[5:0]};
          1: lead = {4'hF, r[3:0]};
          default: lead = {4'hE, r[3:0]};
        endcase
        send_byte(lead, pick_fin());
        r = 8'($urandom);
        send_byte({2'b10, r[5:0]}, pick_fin());
        r = 8'($urandom);
        send_byte({2'b10, r[5:0]}, pick_fin());
        n += 3;
      end else begin
        send_byte(r, pick_fin());
        n += 1;
      end
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    rst_n     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ascii();
    test_two_byte();
    test_three_byte();
    test_broken();
    test_truncated();
    test_random();
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_units.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_front.sv
hw/rtl/utf8d_fifo.sv
hw/rtl/utf8d_back.sv
hw/rtl/utf8_byte_stream_decoder_top.sv
hw/rtl/utf8d_checker.sv
bench/tb_utf8_byte_stream_decoder_top.sv
